// File: rtl/core/gn2d_pkg.sv
`timescale 1ns / 1ps
package gn2d_pkg;
    localparam int TABLE_SIZE_DEF = 256;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int OUT_W          = 18;
    localparam int COORD_W        = 32;
    localparam int OUT_FRAC       = 16;
    localparam logic OP_LOAD      = 1'b0;
    localparam logic OP_EVAL      = 1'b1;
endpackage

// File: rtl/core/gradient_noise_2d_top.sv
`timescale 1ns / 1ps
// Two-dimensional gradient noise generator.
// The input channel (in_valid / in_stall) carries one item per handshake. An item
// with operation = load writes table_value into permutation entry table_index and
// gives no result. An item with operation = evaluate samples the noise at the
// signed fixed-point point (x_coord, y_coord) and gives one noise_value item on
// the output channel (out_valid / out_stall), in Q2.16, rounded and saturated.
// The pipeline takes one item per cycle while it is not stalled. An evaluate item
// passes through two table read stages, one dot product stage, four fade
// stages and the interpolation and output stages on its way to the output.
// Table lookups go through six copies of the permutation memory (two row reads,
// then four corner reads), each a registered read; the copies receive every
// load write.
// A load followed in the next cycles by an evaluate sees the new entry, because
// the write reaches each copy before any later read of it.
// When the receiver stalls a valid output, the whole pipeline freezes and in_stall
// rises, so no item is lost; the output register holds its value until it is taken.
// Reset clears all valid bits; the table contents are undefined until written.
module gradient_noise_2d_top #(
    parameter int FRAC_BITS  = gn2d_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              operation,
    input  logic [7:0]                        table_index,
    input  logic [7:0]                        table_value,
    input  logic signed [gn2d_pkg::COORD_W-1:0] x_coord,
    input  logic signed [gn2d_pkg::COORD_W-1:0] y_coord,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [gn2d_pkg::OUT_W-1:0] noise_value
);
    import gn2d_pkg::*;

    localparam int TABLE_SIZE = TABLE_SIZE_DEF;
    localparam int AW  = $clog2(TABLE_SIZE);
    localparam int FB  = FRAC_BITS;
    localparam int FW  = FB + 2;            // fraction/fade values, signed
    localparam int DW  = FB + 3;            // dot products, |d| <= 2
    localparam int XW  = FB + 5;            // fade polynomial terms and interpolants
    localparam int PW  = 2 * DW + 2;        // product width

    // Pipeline advances whenever output is free or being taken.
    logic adv;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    logic acc;
    assign acc = in_valid && adv;

    function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] w;
        begin
            w = p + (PW'(1) <<< (FB - 1));
            rnd = w >>> FB;
        end
    endfunction

    // Fixed-point product of a fraction-width and an interpolant-width value.
    function automatic logic signed [PW-1:0] mulq(input logic signed [FW-1:0] a,
        input logic signed [XW-1:0] b);
        logic signed [FW+XW-1:0] p;
        begin
            p = a * b;
            mulq = rnd(PW'(p));
        end
    endfunction

    // ---------------- stage 1: split coordinates, load writes ----------------
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    assign we    = acc && (operation == OP_LOAD);
    assign waddr = table_index[AW-1:0] ;
    assign wdata = table_value;

    logic [AW-1:0] xi, yi;
    assign xi = x_coord[FB +: AW];
    assign yi = y_coord[FB +: AW];

    logic                 v1_reg;
    logic [AW-1:0]        ii1_reg;
    logic signed [FW-1:0] fx1_reg, fy1_reg;

    // two row reads: p[j] and p[j+1]
    logic [7:0] pj, pj1;
    gn2d_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ra (.clk(clk), .we(we), .waddr(waddr),
        .wdata(wdata), .raddr(yi), .rdata(pj));
    gn2d_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_rb (.clk(clk), .we(we), .waddr(waddr),
        .wdata(wdata), .raddr(AW'(yi + AW'(1))), .rdata(pj1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= acc && (operation == OP_EVAL);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ii1_reg <= xi;
            fx1_reg <= FW'({1'b0, x_coord[FB-1:0]});
            fy1_reg <= FW'({1'b0, y_coord[FB-1:0]});
        end
    end

    // Reads are issued every cycle; on stall the read data would change, so a
    // shadow register keeps the captured data from the cycle the stall began.
    logic       adv_d_reg;
    logic [7:0] pj_h_reg, pj1_h_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adv_d_reg <= 1'b1;
        end
        else
        begin
            adv_d_reg <= adv;
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv_d_reg)
        begin
            pj_h_reg  <= pj;
            pj1_h_reg <= pj1;
        end
    end
    logic [7:0] pj_s, pj1_s;
    assign pj_s  = adv_d_reg ? pj : pj_h_reg;
    assign pj1_s = adv_d_reg ? pj1 : pj1_h_reg;

    // ---------------- stage 2: corner hash addresses ----------------
    logic [AW-1:0] a00, a10, a11, a01;
    assign a00 = AW'(ii1_reg + AW'(pj_s));
    assign a10 = AW'(ii1_reg + AW'(1) + AW'(pj_s));
    assign a11 = AW'(ii1_reg + AW'(1) + AW'(pj1_s));
    assign a01 = AW'(ii1_reg + AW'(pj1_s));

    logic [7:0] g00, g10, g11, g01;
    gn2d_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_c0 (.clk(clk), .we(we), .waddr(waddr),
        .wdata(wdata), .raddr(a00), .rdata(g00));
    gn2d_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_c1 (.clk(clk), .we(we), .waddr(waddr),
        .wdata(wdata), .raddr(a10), .rdata(g10));
    gn2d_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_c2 (.clk(clk), .we(we), .waddr(waddr),
        .wdata(wdata), .raddr(a11), .rdata(g11));
    gn2d_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_c3 (.clk(clk), .we(we), .waddr(waddr),
        .wdata(wdata), .raddr(a01), .rdata(g01));

    logic                 v2_reg;
    logic signed [FW-1:0] fx2_reg, fy2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fx2_reg <= fx1_reg;
            fy2_reg <= fy1_reg;
        end
    end

    // Hold corner read data across stalls in the same way as the row reads.
    logic [2:0] h0_reg, h1_reg, h2_reg, h3_reg;
    always_ff @(posedge clk)
    begin
        if (adv_d_reg)
        begin
            h0_reg <= g00[2:0];
            h1_reg <= g10[2:0];
            h2_reg <= g11[2:0];
            h3_reg <= g01[2:0];
        end
    end
    logic [2:0] s0, s1, s2, s3;
    assign s0 = adv_d_reg ? g00[2:0] : h0_reg;
    assign s1 = adv_d_reg ? g10[2:0] : h1_reg;
    assign s2 = adv_d_reg ? g11[2:0] : h2_reg;
    assign s3 = adv_d_reg ? g01[2:0] : h3_reg;

    // ---------------- stage 3: dot products ----------------
    function automatic logic signed [DW-1:0] dotp(input logic [2:0] g,
        input logic signed [DW-1:0] dx, input logic signed [DW-1:0] dy);
        logic signed [DW-1:0] ex, ey;
        begin
            unique case (g)
                3'd0: begin ex = dx;  ey = dy;  end
                3'd1: begin ex = -dx; ey = dy;  end
                3'd2: begin ex = dx;  ey = -dy; end
                3'd3: begin ex = -dx; ey = -dy; end
                3'd4: begin ex = dx;  ey = '0;  end
                3'd5: begin ex = -dx; ey = '0;  end
                3'd6: begin ex = '0;  ey = dy;  end
                default: begin ex = '0; ey = -dy; end
            endcase
            dotp = ex + ey;
        end
    endfunction

    logic signed [DW-1:0] dx0, dy0, dx1, dy1, one_q;
    assign one_q = DW'(1) <<< FB;
    assign dx0 = DW'(fx2_reg);
    assign dy0 = DW'(fy2_reg);
    assign dx1 = dx0 - one_q;
    assign dy1 = dy0 - one_q;

    logic                 v3_reg;
    logic signed [DW-1:0] ds_reg, dt_reg, dv_reg, du_reg;
    logic signed [FW-1:0] fx3_reg, fy3_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= v2_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ds_reg  <= dotp(s0, dx0, dy0);
            dt_reg  <= dotp(s1, dx1, dy0);
            dv_reg  <= dotp(s2, dx1, dy1);
            du_reg  <= dotp(s3, dx0, dy1);
            fx3_reg <= fx2_reg;
            fy3_reg <= fy2_reg;
        end
    end

    // ---------------- stages 4..7: fade on both axes ----------------
    // Carried values: dot products travel along in a delay line.
    localparam int FD = 4;
    logic signed [DW-1:0] dsl_reg [FD], dtl_reg [FD], dvl_reg [FD], dul_reg [FD];
    logic                 vl_reg  [FD];
    // fade stage a: t*t and 6t-15
    logic signed [XW-1:0] ax_reg, ay_reg;
    logic signed [FW-1:0] tt_x_reg, tt_y_reg;
    logic signed [FW-1:0] tx_a_reg, ty_a_reg;
    // stage b: t*a + 10, tt*t
    logic signed [XW-1:0] bx_reg, by_reg;
    logic signed [FW-1:0] t3x_reg, t3y_reg;
    // stage c: f = t3*b, then clamp in stage d
    logic signed [XW-1:0] fxp_reg, fyp_reg;
    logic signed [FW-1:0] cx_reg, cy_reg;

    function automatic logic signed [FW-1:0] clampf(input logic signed [XW-1:0] f);
        begin
            if (f < 0)
                clampf = '0;
            else if (f > (XW'(1) <<< FB))
                clampf = FW'(1) <<< FB;
            else
                clampf = FW'(f);
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < FD; k++)
            begin
                vl_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vl_reg[0] <= v3_reg;
            for (int k = 1; k < FD; k++)
            begin
                vl_reg[k] <= vl_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dsl_reg[0] <= ds_reg; dtl_reg[0] <= dt_reg;
            dvl_reg[0] <= dv_reg; dul_reg[0] <= du_reg;
            for (int k = 1; k < FD; k++)
            begin
                dsl_reg[k] <= dsl_reg[k-1]; dtl_reg[k] <= dtl_reg[k-1];
                dvl_reg[k] <= dvl_reg[k-1]; dul_reg[k] <= dul_reg[k-1];
            end
            // a
            ax_reg   <= XW'(6) * XW'(fx3_reg) - (XW'(15) <<< FB);
            ay_reg   <= XW'(6) * XW'(fy3_reg) - (XW'(15) <<< FB);
            tt_x_reg <= FW'(mulq(fx3_reg, XW'(fx3_reg)));
            tt_y_reg <= FW'(mulq(fy3_reg, XW'(fy3_reg)));
            tx_a_reg <= fx3_reg;
            ty_a_reg <= fy3_reg;
            // b
            bx_reg  <= XW'(mulq(tx_a_reg, ax_reg)) + (XW'(10) <<< FB);
            by_reg  <= XW'(mulq(ty_a_reg, ay_reg)) + (XW'(10) <<< FB);
            t3x_reg <= FW'(mulq(tt_x_reg, XW'(tx_a_reg)));
            t3y_reg <= FW'(mulq(tt_y_reg, XW'(ty_a_reg)));
            // c
            fxp_reg <= XW'(mulq(t3x_reg, bx_reg));
            fyp_reg <= XW'(mulq(t3y_reg, by_reg));
            // d
            cx_reg <= clampf(fxp_reg);
            cy_reg <= clampf(fyp_reg);
        end
    end
    // dot products at index 3 align with cx_reg/cy_reg (4 stages after stage 3).

    // ---------------- stages: interpolation ----------------
    logic signed [PW-1:0] e1_reg, e2_reg, m_reg, r_reg;
    logic signed [DW-1:0] s1_reg, u1_reg;
    logic signed [XW-1:0] l1_reg, l2_reg, l1b_reg;
    logic signed [FW-1:0] cy1_reg, cy2_reg;
    logic                 vi1_reg, vi2_reg, vi3_reg, vo4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vi1_reg <= 1'b0;
            vi2_reg <= 1'b0;
            vi3_reg <= 1'b0;
            vo4_reg <= 1'b0;
        end
        else if (adv)
        begin
            vi1_reg <= vl_reg[3];
            vi2_reg <= vi1_reg;
            vi3_reg <= vi2_reg;
            vo4_reg <= vi3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_reg  <= mulq(cx_reg, XW'(dtl_reg[3]) - XW'(dsl_reg[3]));
            e2_reg  <= mulq(cx_reg, XW'(dvl_reg[3]) - XW'(dul_reg[3]));
            s1_reg  <= dsl_reg[3];
            u1_reg  <= dul_reg[3];
            cy1_reg <= cy_reg;
            l1_reg  <= XW'(s1_reg) + XW'(e1_reg);
            l2_reg  <= XW'(u1_reg) + XW'(e2_reg);
            cy2_reg <= cy1_reg;
            m_reg   <= mulq(cy2_reg, l2_reg - l1_reg);
            l1b_reg <= l1_reg;
            r_reg   <= PW'(l1b_reg) + m_reg;
        end
    end

    // final scaling to Q.16 and saturation
    logic signed [PW+OUT_FRAC:0] rs;
    always_comb
    begin
        if (FB >= OUT_FRAC)
        begin
            if (FB == OUT_FRAC)
                rs = (PW+OUT_FRAC+1)'(r_reg);
            else
                rs = ((PW+OUT_FRAC+1)'(r_reg) + ((PW+OUT_FRAC+1)'(1) <<< (FB-OUT_FRAC-1)))
                     >>> (FB - OUT_FRAC);
        end
        else
        begin
            rs = (PW+OUT_FRAC+1)'(r_reg) <<< (OUT_FRAC - FB);
        end
    end

    logic signed [OUT_W-1:0] sat;
    always_comb
    begin
        if (rs > (PW+OUT_FRAC+1)'(131071))
            sat = OUT_W'(131071);
        else if (rs < -(PW+OUT_FRAC+1)'(131072))
            sat = OUT_W'(-131072);
        else
            sat = OUT_W'(rs);
    end

    logic                    ov_reg;
    logic signed [OUT_W-1:0] nv_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            ov_reg <= vo4_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nv_reg <= sat;
        end
    end
    assign out_valid   = ov_reg;
    assign noise_value = nv_reg;
endmodule

// File: rtl/core/gn2d_ram.sv
`timescale 1ns / 1ps
module gn2d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
